// File: design/pst_pkg.sv
`default_nettype none
package pst_pkg;

	localparam int ID_W       = 32;
	localparam int SIZE_W     = 8;
	localparam int SLOT_OUT_W = 7;
	localparam int MOD_CNT_W  = 6;

	localparam logic [SIZE_W-1:0]    SIZE_RESET = 8'd100;
	localparam logic [MOD_CNT_W-1:0] MOD_STEPS  = 6'd32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic take_hit;
		logic write_miss;
	} pst_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic match;
		logic scan_done;
		logic mod_done;
	} pst_stat_t;

endpackage
`default_nettype wire

// File: design/pst_ram.sv
`default_nettype none
module pst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: design/pst_ctrl.sv
`default_nettype none
module pst_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire pst_pkg::pst_stat_t stat,
	output pst_pkg::pst_cmd_t       cmd,
	output logic                    busy,
	output logic                    done
);

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t state_q;
	logic   done_q;

	// The search ends on the first match; a miss waits for both the scan and the modulo.
	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == ST_IDLE) && start;
		cmd.scan       = (state_q == ST_SEARCH) && !stat.match;
		cmd.take_hit   = (state_q == ST_SEARCH) && stat.match;
		cmd.write_miss = (state_q == ST_SEARCH) && !stat.match && stat.scan_done
			&& stat.mod_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.take_hit || cmd.write_miss;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (cmd.take_hit || cmd.write_miss) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

// File: design/pst_dp.sv
`default_nettype none
module pst_dp #(
	parameter int TABLE_DEPTH = 128
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pst_pkg::pst_cmd_t             cmd,
	output pst_pkg::pst_stat_t                 stat,
	input  wire logic                          cfg_we,
	input  wire logic [pst_pkg::SIZE_W-1:0]    cfg_data,
	input  wire logic [pst_pkg::ID_W-1:0]      payload_id,
	input  wire logic [pst_pkg::ID_W-1:0]      source_addr,
	output logic      [pst_pkg::SLOT_OUT_W-1:0] slot_index,
	output logic                               hit
);

	// The size register is 8 bits wide, so no slot above 254 is ever reached.
	localparam int SIZE_CAP = (TABLE_DEPTH < 255) ? TABLE_DEPTH : 255;
	localparam int ADDR_W   = $clog2(SIZE_CAP);
	localparam int SW       = pst_pkg::SIZE_W;
	localparam int IW       = pst_pkg::ID_W;
	localparam int CW       = pst_pkg::MOD_CNT_W;
	localparam logic [SW-1:0] SIZE_CAP_V = SW'(SIZE_CAP);

	logic [SW-1:0]                  size_q;
	logic [SIZE_CAP-1:0]            valid_q;
	logic [IW-1:0]                  id_q;
	logic [IW-1:0]                  addr_q;
	logic [IW-1:0]                  sum_q;
	logic [SW-1:0]                  rem_q;
	logic [pst_pkg::MOD_CNT_W-1:0]  mod_cnt_q;
	logic [SW-1:0]                  scan_q;
	logic                           chk_en_s1;
	logic                           chk_vld_s1;
	logic [SW-1:0]                  chk_slot_s1;
	logic [SW-1:0]                  res_slot_q;
	logic                           res_hit_q;
	logic [SW-1:0]                  n_used;
	logic                           issue;
	logic [SW:0]                    mod_trial;
	logic [SW-1:0]                  rem_next;
	logic [2*IW-1:0]                rd_data;

	always_comb begin
		if (size_q == '0) begin
			n_used = SW'(1);
		end else if (size_q > SIZE_CAP_V) begin
			n_used = SIZE_CAP_V;
		end else begin
			n_used = size_q;
		end
	end

	assign issue = cmd.scan && (scan_q < n_used);

	// Restoring remainder step, one dividend bit per cycle.
	assign mod_trial = {rem_q, sum_q[IW-1]};
	assign rem_next  = (mod_trial >= {1'b0, n_used}) ? SW'(mod_trial - {1'b0, n_used})
		: mod_trial[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= pst_pkg::SIZE_RESET;
			valid_q   <= '0;
			mod_cnt_q <= '0;
			scan_q    <= '0;
			chk_en_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q  <= cfg_data;
				valid_q <= '0;
			end else if (cmd.write_miss) begin
				valid_q[ADDR_W'(rem_q)] <= 1'b1;
			end
			if (cmd.load) begin
				mod_cnt_q <= pst_pkg::MOD_STEPS;
				scan_q    <= '0;
			end else begin
				if (mod_cnt_q != '0) begin
					mod_cnt_q <= mod_cnt_q - CW'(1);
				end
				if (issue) begin
					scan_q <= scan_q + SW'(1);
				end
			end
			chk_en_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q   <= payload_id;
			addr_q <= source_addr;
			sum_q  <= payload_id + source_addr;
			rem_q  <= '0;
		end else if (mod_cnt_q != '0) begin
			sum_q <= {sum_q[IW-2:0], 1'b0};
			rem_q <= rem_next;
		end
		chk_vld_s1  <= valid_q[ADDR_W'(scan_q)];
		chk_slot_s1 <= scan_q;
		if (cmd.take_hit) begin
			res_slot_q <= chk_slot_s1;
			res_hit_q  <= 1'b1;
		end else if (cmd.write_miss) begin
			res_slot_q <= rem_q;
			res_hit_q  <= 1'b0;
		end
	end

	pst_ram #(
		.WIDTH(2 * IW),
		.DEPTH(SIZE_CAP)
	) u_slot_ram (
		.clk  (clk),
		.we   (cmd.write_miss),
		.waddr(ADDR_W'(rem_q)),
		.wdata({id_q, addr_q}),
		.raddr(ADDR_W'(scan_q)),
		.rdata(rd_data)
	);

	always_comb begin
		stat           = '0;
		stat.match     = chk_en_s1 && chk_vld_s1 && (rd_data == {id_q, addr_q});
		stat.scan_done = (scan_q >= n_used) && !chk_en_s1;
		stat.mod_done  = (mod_cnt_q == '0);
	end

	assign slot_index = res_slot_q[pst_pkg::SLOT_OUT_W-1:0];
	assign hit        = res_hit_q;

endmodule
`default_nettype wire

// File: design/payload_slot_table_core.sv
`default_nettype none
// Payload slot table: looks up a (payload_id, source_addr) pair among the valid
// slots of a table and returns the first slot that holds it, or on a miss writes
// the pair into slot ((payload_id + source_addr) mod 2^32) mod size.
// Request channel: a transaction is taken at a rising edge with start high and
// busy low. Result channel: done is high for exactly one cycle with slot_index
// and hit valid; the receiver cannot stall it, and the values hold until the
// next result. Configuration: cfg_data is written to the size register at an edge
// with cfg_valid and cfg_ready high; cfg_ready is high only while the block is
// idle, and every write clears all valid marks.
// A hit in slot k ends the lookup once the scan has compared slot k. A miss
// ends it only when both the one-slot-per-cycle scan of the first n slots,
// where n is the size in use, and the 32-step serial remainder unit, which run
// side by side, are through. A new request can be accepted in the cycle that
// done is shown.
// Reset clears the valid marks and loads a table size of 100; slot contents
// need no clearing, since only valid slots are compared.
module payload_slot_table_core #(
	parameter int TABLE_DEPTH = 128
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [pst_pkg::ID_W-1:0]        payload_id,
	input  wire logic [pst_pkg::ID_W-1:0]        source_addr,
	output logic                                 done,
	output logic      [pst_pkg::SLOT_OUT_W-1:0]  slot_index,
	output logic                                 hit,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pst_pkg::SIZE_W-1:0]      cfg_data
);

	pst_pkg::pst_cmd_t  cmd;
	pst_pkg::pst_stat_t stat;
	logic               cfg_we;

	// The size may only change between lookups, so the port is held off while busy.
	assign cfg_ready = !busy;
	assign cfg_we    = cfg_valid && cfg_ready;

	pst_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	pst_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.payload_id (payload_id),
		.source_addr(source_addr),
		.slot_index (slot_index),
		.hit        (hit)
	);

	// A result is only produced as the lookup finishes, so the block is idle then.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a lookup is still running");

	// Every result needs a fresh transaction, so the result strobe is never repeated.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// An accepted transaction starts a lookup.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not start a lookup");

	// A lookup in flight produces no result until it finishes.
	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> !done)
		else $error("result strobe in the middle of a lookup");

endmodule
`default_nettype wire
